>>> sv/mss_pkg.sv
// Shared types, codes and constants of the modem session sequencer.
package mss_pkg;

    localparam int unsigned TimeoutWidth = 16;
    localparam int unsigned RetryWidth   = 4;
    localparam int unsigned OtaWidth     = 8;
    localparam int unsigned ApbAddrWidth = 3;
    localparam int unsigned ApbDataWidth = 32;
    localparam int unsigned InDataWidth  = 32;
    localparam int unsigned InUserWidth  = 2;
    localparam int unsigned OutDataWidth = 16;

    localparam logic [TimeoutWidth-1:0] LinkTimeoutReset = 16'd600;
    localparam logic [RetryWidth-1:0]   MaxPowerCyclesReset = 4'd1;
    localparam logic [RetryWidth-1:0]   RetryMax = 4'd15;

    // Register indexes on the configuration port.
    localparam logic REG_LINK_TIMEOUT = 1'b0;
    localparam logic REG_MAX_POWER    = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK         = 2'd0,
        OP_START        = 2'd1,
        OP_SEND_ANOTHER = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_GRAB         = 4'd1,
        PH_WAIT_UP      = 4'd2,
        PH_SEND         = 4'd3,
        PH_SEND_WAIT    = 4'd4,
        PH_WAIT_LINK    = 4'd5,
        PH_OTA          = 4'd6,
        PH_OTA_WAIT     = 4'd7,
        PH_RELEASE      = 4'd8,
        PH_RELEASE_WAIT = 4'd9
    } phase_t;

    typedef struct packed {
        logic [TimeoutWidth-1:0] link_timeout_secs;
        logic [RetryWidth-1:0]   max_power_cycles;
    } cfg_t;

    typedef struct packed {
        phase_t                phase;
        logic [RetryWidth-1:0] retry_count;
        logic                  sent;
        logic                  finished;
        logic                  error;
        logic                  timeout;
    } state_t;

    typedef struct packed {
        logic [1:0]              op;
        logic                    grab_granted;
        logic                    modem_up;
        logic                    cmd_error;
        logic                    cmd_complete;
        logic                    link_up;
        logic                    link_error;
        logic [TimeoutWidth-1:0] modem_on_secs;
        logic [OtaWidth-1:0]     ota_pending;
        logic                    ota_done;
        logic                    release_complete;
    } in_item_t;

    typedef struct packed {
        logic [3:0] phase;
        logic       grab_request;
        logic       send_batch;
        logic       status_only;
        logic       stop_batch;
        logic       restart_modem;
        logic       start_ota;
        logic       release_modem;
        logic       send_done;
        logic       all_done;
        logic       comm_error;
        logic       connect_timeout;
    } out_item_t;

endpackage

>>> sv/mss_cfg.sv
// APB register file holding the link timeout and power-cycle limit.
module mss_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mss_pkg::ApbAddrWidth-1:0]    paddr,
    input  logic [mss_pkg::ApbDataWidth-1:0]    pwdata,
    output logic [mss_pkg::ApbDataWidth-1:0]    prdata,
    output logic                                pready,
    output mss_pkg::cfg_t                       cfg
);

    mss_pkg::cfg_t cfg_reg;
    mss_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Only the word index is decoded; byte offsets inside a word alias to it.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                mss_pkg::REG_LINK_TIMEOUT: begin
                    cfg_next.link_timeout_secs = pwdata[mss_pkg::TimeoutWidth-1:0];
                end
                mss_pkg::REG_MAX_POWER: begin
                    cfg_next.max_power_cycles = pwdata[mss_pkg::RetryWidth-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_timeout_secs <= mss_pkg::LinkTimeoutReset;
            cfg_reg.max_power_cycles  <= mss_pkg::MaxPowerCyclesReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            mss_pkg::REG_LINK_TIMEOUT: begin
                prdata = {{(mss_pkg::ApbDataWidth-mss_pkg::TimeoutWidth){1'b0}},
                          cfg_reg.link_timeout_secs};
            end
            mss_pkg::REG_MAX_POWER: begin
                prdata = {{(mss_pkg::ApbDataWidth-mss_pkg::RetryWidth){1'b0}},
                          cfg_reg.max_power_cycles};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/mss_step.sv
// Next-state and strobe logic for one item; the grab-to-send and link-to-OTA chains are resolved in it.
module mss_step (
    input  mss_pkg::state_t   st,
    input  mss_pkg::cfg_t     cfg,
    input  mss_pkg::in_item_t item,
    output mss_pkg::state_t   st_next,
    output mss_pkg::out_item_t result
);

    logic                              s_grab;
    logic                              s_send;
    logic                              s_status;
    logic                              s_stop;
    logic                              s_restart;
    logic                              s_ota;
    logic                              s_release;
    logic [mss_pkg::RetryWidth-1:0]    retry_inc;
    logic                              link_gave_up;

    assign retry_inc = (st.retry_count == mss_pkg::RetryMax) ? mss_pkg::RetryMax
                                                             : st.retry_count + 1'b1;
    assign link_gave_up = item.link_error ||
                          (item.modem_on_secs > cfg.link_timeout_secs);

    always_comb begin
        st_next   = st;
        s_grab    = 1'b0;
        s_send    = 1'b0;
        s_status  = 1'b0;
        s_stop    = 1'b0;
        s_restart = 1'b0;
        s_ota     = 1'b0;
        s_release = 1'b0;
        unique case (item.op)
            mss_pkg::OP_START: begin
                st_next.retry_count = '0;
                st_next.sent        = 1'b0;
                st_next.finished    = 1'b0;
                st_next.error       = 1'b0;
                st_next.timeout     = 1'b0;
                st_next.phase       = mss_pkg::PH_GRAB;
            end
            mss_pkg::OP_SEND_ANOTHER: begin
                st_next.phase = mss_pkg::PH_SEND;
                st_next.sent  = 1'b0;
            end
            mss_pkg::OP_TICK: begin
                // A send always lands in send wait with the command flags
                // treated as clear, so that phase does nothing more this tick.
                unique case (st.phase)
                    mss_pkg::PH_GRAB: begin
                        s_grab = 1'b1;
                        if (item.grab_granted) begin
                            if (item.modem_up) begin
                                s_send        = 1'b1;
                                st_next.phase = mss_pkg::PH_SEND_WAIT;
                            end else begin
                                st_next.phase = mss_pkg::PH_WAIT_UP;
                            end
                        end
                    end
                    mss_pkg::PH_WAIT_UP: begin
                        if (item.modem_up) begin
                            s_send        = 1'b1;
                            st_next.phase = mss_pkg::PH_SEND_WAIT;
                        end
                    end
                    mss_pkg::PH_SEND: begin
                        s_send        = 1'b1;
                        st_next.phase = mss_pkg::PH_SEND_WAIT;
                    end
                    mss_pkg::PH_SEND_WAIT: begin
                        if (item.cmd_error) begin
                            st_next.retry_count = retry_inc;
                            if (retry_inc > cfg.max_power_cycles) begin
                                st_next.error = 1'b1;
                                st_next.phase = mss_pkg::PH_RELEASE;
                            end else begin
                                s_stop        = 1'b1;
                                s_restart     = 1'b1;
                                st_next.phase = mss_pkg::PH_WAIT_UP;
                            end
                        end else if (item.cmd_complete) begin
                            st_next.sent  = 1'b1;
                            st_next.phase = item.link_up ? mss_pkg::PH_OTA
                                                         : mss_pkg::PH_WAIT_LINK;
                        end
                    end
                    mss_pkg::PH_WAIT_LINK: begin
                        if (item.link_up || link_gave_up) begin
                            if (!item.link_up) begin
                                st_next.timeout = 1'b1;
                            end
                            // The OTA phase is evaluated in the same tick.
                            if (item.ota_pending != '0) begin
                                s_ota         = 1'b1;
                                st_next.phase = mss_pkg::PH_OTA_WAIT;
                            end else begin
                                st_next.phase = mss_pkg::PH_RELEASE;
                            end
                        end else begin
                            s_send        = 1'b1;
                            s_status      = 1'b1;
                            st_next.phase = mss_pkg::PH_SEND_WAIT;
                        end
                    end
                    mss_pkg::PH_OTA: begin
                        if (item.ota_pending != '0) begin
                            s_ota         = 1'b1;
                            st_next.phase = mss_pkg::PH_OTA_WAIT;
                        end else begin
                            st_next.phase = mss_pkg::PH_RELEASE;
                        end
                    end
                    mss_pkg::PH_OTA_WAIT: begin
                        if (item.ota_done) begin
                            st_next.phase = mss_pkg::PH_RELEASE;
                        end
                    end
                    mss_pkg::PH_RELEASE: begin
                        s_release     = 1'b1;
                        st_next.phase = mss_pkg::PH_RELEASE_WAIT;
                    end
                    mss_pkg::PH_RELEASE_WAIT: begin
                        if (item.release_complete) begin
                            st_next.sent     = 1'b1;
                            st_next.finished = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result.phase           = st_next.phase;
        result.grab_request    = s_grab;
        result.send_batch      = s_send;
        result.status_only     = s_send && s_status;
        result.stop_batch      = s_stop;
        result.restart_modem   = s_restart;
        result.start_ota       = s_ota;
        result.release_modem   = s_release;
        result.send_done       = st_next.sent;
        result.all_done        = st_next.finished;
        result.comm_error      = st_next.error;
        result.connect_timeout = st_next.timeout;
    end

endmodule

>>> sv/modem_session_sequencer.sv
// Top level of the modem session sequencer: input stage, state, result register.
//
// Each input transfer on the s_ channel is one item: a status tick (s_tuser = 0),
// a start-session command (1) or a send-another command (2). Every item gives
// exactly one result transfer on the m_ channel with the phase after the item,
// the command strobes raised while it was handled and the session flags.
// An accepted item is held in the input register, evaluated by the
// single-pass phase logic and then stored in the result register. The
// grab-to-send and link-to-OTA chains inside one tick are resolved in that
// one evaluation; a new item can be taken in every cycle, and throughput is
// one item per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready then drops until the result is taken.
// The APB port sets the link timeout and the power-cycle limit; write it only
// while no item is in flight. A synchronous reset (aresetn low) empties both
// stages, returns the phase to idle with all flags and the retry count cleared,
// and restores the register defaults.
module modem_session_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // grab_granted, modem_up, cmd_error, cmd_complete, link_up, link_error,
    // modem_on_secs[15:0], ota_pending[7:0], ota_done, release_complete
    input  logic [mss_pkg::InDataWidth-1:0]     s_tdata,
    // op[1:0]
    input  logic [mss_pkg::InUserWidth-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // phase[3:0], grab_request, send_batch, status_only, stop_batch, restart_modem,
    // start_ota, release_modem, send_done, all_done, comm_error, connect_timeout,
    // one zero bit
    output logic [mss_pkg::OutDataWidth-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mss_pkg::ApbAddrWidth-1:0]    paddr,
    input  logic [mss_pkg::ApbDataWidth-1:0]    pwdata,
    output logic [mss_pkg::ApbDataWidth-1:0]    prdata,
    output logic                                pready
);

    mss_pkg::cfg_t      cfg;
    mss_pkg::in_item_t  s_item;
    mss_pkg::in_item_t  in_item_reg;
    logic               in_valid_reg;
    mss_pkg::state_t    state_reg;
    mss_pkg::state_t    state_next;
    mss_pkg::out_item_t result;
    mss_pkg::out_item_t out_item_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               s_xfer;

    mss_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        s_item.op               = s_tuser;
        s_item.grab_granted     = s_tdata[0];
        s_item.modem_up         = s_tdata[1];
        s_item.cmd_error        = s_tdata[2];
        s_item.cmd_complete     = s_tdata[3];
        s_item.link_up          = s_tdata[4];
        s_item.link_error       = s_tdata[5];
        s_item.modem_on_secs    = s_tdata[21:6];
        s_item.ota_pending      = s_tdata[29:22];
        s_item.ota_done         = s_tdata[30];
        s_item.release_complete = s_tdata[31];
    end

    // The held item moves on whenever the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    mss_step u_step (
        .st      (state_reg),
        .cfg     (cfg),
        .item    (in_item_reg),
        .st_next (state_next),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.phase       <= mss_pkg::PH_IDLE;
            state_reg.retry_count <= '0;
            state_reg.sent        <= 1'b0;
            state_reg.finished    <= 1'b0;
            state_reg.error       <= 1'b0;
            state_reg.timeout     <= 1'b0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_item_reg.connect_timeout,
                       out_item_reg.comm_error,
                       out_item_reg.all_done,
                       out_item_reg.send_done,
                       out_item_reg.release_modem,
                       out_item_reg.start_ota,
                       out_item_reg.restart_modem,
                       out_item_reg.stop_batch,
                       out_item_reg.status_only,
                       out_item_reg.send_batch,
                       out_item_reg.grab_request,
                       out_item_reg.phase};

endmodule

>>> sv/mss_checker.sv
// Port-level checks for the modem session sequencer, bound to the top level.
module mss_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mss_pkg::OutDataWidth-1:0]    m_tdata
);

    // A result that is not taken must stay as it is.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // A status-only flag is meaningful only alongside a send strobe.
    a_status_with_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> m_tdata[5])
        else $error("status_only without send_batch");

    // A power cycle aborts the batch and waits for the modem to come up again.
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[7] && m_tdata[3:0] == mss_pkg::PH_WAIT_UP)
        else $error("restart_modem without stop_batch or outside wait-up");

    // A release strobe always leaves the session waiting for the release.
    a_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[3:0] == mss_pkg::PH_RELEASE_WAIT)
        else $error("release_modem outside release wait");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind modem_session_sequencer mss_checker u_mss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
